// File: rtl/button_gesture_led_controller_top_defines.svh
// ----------------------------------------------------------------------------
// button gesture led controller assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_LED_CONTROLLER_TOP_DEFINES_SVH
`define BUTTON_GESTURE_LED_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BGL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BGL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bgl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgl_pkg
// shared types and constants of the button gesture led controller
// ----------------------------------------------------------------------------
package bgl_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 8;

	// register reset values
	localparam logic [TICK_W-1:0]  DEBOUNCE_RST   = 16'd50;
	localparam logic [TICK_W-1:0]  CLICK_RST      = 16'd500;
	localparam logic [TICK_W-1:0]  RELAX_RST      = 16'd300;
	localparam logic [TICK_W-1:0]  HOLD_RST       = 16'd3000;
	localparam logic [TICK_W-1:0]  FLASH_HALF_RST = 16'd100;
	localparam logic [COUNT_W-1:0] FLASH_CNT_RST  = 4'd5;

	typedef enum logic [INDEX_W-1:0] {
		REG_DEBOUNCE   = 3'd0,
		REG_CLICK      = 3'd1,
		REG_RELAX      = 3'd2,
		REG_HOLD       = 3'd3,
		REG_FLASH_HALF = 3'd4,
		REG_FLASH_CNT  = 3'd5
	} reg_index_t;

	typedef enum logic [2:0] {
		GEST_NONE   = 3'd0,
		GEST_SINGLE = 3'd1,
		GEST_DOUBLE = 3'd2,
		GEST_HOLD   = 3'd3,
		GEST_NOISE  = 3'd4
	} gesture_t;

	typedef struct packed {
		logic [TICK_W-1:0]  debounce_ticks;
		logic [TICK_W-1:0]  click_ticks;
		logic [TICK_W-1:0]  relax_ticks;
		logic [TICK_W-1:0]  hold_ticks;
		logic [TICK_W-1:0]  flash_half_ticks;
		logic [COUNT_W-1:0] flash_count;
	} cfg_t;

	typedef struct packed {
		logic     led_three;
		logic     led_two;
		logic     led_one;
		gesture_t gesture;
	} result_t;

endpackage

// File: rtl/bgl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgl_cfg
// configuration register file, written by index
// ----------------------------------------------------------------------------
module bgl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [bgl_pkg::INDEX_W-1:0]   wr_index,
	input  logic [bgl_pkg::TICK_W-1:0]    wr_data,
	output bgl_pkg::cfg_t                 cfg
);

	bgl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= bgl_pkg::DEBOUNCE_RST;
			cfg_q.click_ticks      <= bgl_pkg::CLICK_RST;
			cfg_q.relax_ticks      <= bgl_pkg::RELAX_RST;
			cfg_q.hold_ticks       <= bgl_pkg::HOLD_RST;
			cfg_q.flash_half_ticks <= bgl_pkg::FLASH_HALF_RST;
			cfg_q.flash_count      <= bgl_pkg::FLASH_CNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				bgl_pkg::REG_DEBOUNCE:   cfg_q.debounce_ticks   <= wr_data;
				bgl_pkg::REG_CLICK:      cfg_q.click_ticks      <= wr_data;
				bgl_pkg::REG_RELAX:      cfg_q.relax_ticks      <= wr_data;
				bgl_pkg::REG_HOLD:       cfg_q.hold_ticks       <= wr_data;
				bgl_pkg::REG_FLASH_HALF: cfg_q.flash_half_ticks <= wr_data;
				bgl_pkg::REG_FLASH_CNT:
					cfg_q.flash_count <= wr_data[bgl_pkg::COUNT_W-1:0];
				default: ; // unknown index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/bgl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgl_core
// gesture state machine and led state, one tick per step
// ----------------------------------------------------------------------------
module bgl_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             pressed,
	input  bgl_pkg::cfg_t    cfg,
	output bgl_pkg::result_t res
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_DEB    = 3'd1,
		PH_PRESS1 = 3'd2,
		PH_GAP1   = 3'd3,
		PH_PRESS2 = 3'd4,
		PH_GAP2   = 3'd5,
		PH_WAIT   = 3'd6,
		PH_FLASH  = 3'd7
	} phase_t;

	localparam logic [bgl_pkg::TICK_W-1:0] TICK_MAX = '1;

	phase_t                        phase_q, phase_d;
	logic [bgl_pkg::TICK_W-1:0]    elapsed_q, elapsed_d, elapsed_inc;
	logic [bgl_pkg::TICK_W-1:0]    ftimer_q, ftimer_d, ftimer_inc;
	logic [1:0]                    pattern_q, pattern_d;
	logic                          enabled_q, enabled_d;
	logic [bgl_pkg::COUNT_W-1:0]   fleft_q, fleft_d, fleft_dec;
	bgl_pkg::gesture_t             gesture;
	logic                          flash_on;

	// saturating counters
	assign elapsed_inc = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign ftimer_inc  = (ftimer_q == TICK_MAX) ? ftimer_q : ftimer_q + 1'b1;
	assign fleft_dec   = (fleft_q != '0) ? fleft_q - 1'b1 : fleft_q;

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		ftimer_d  = ftimer_q;
		pattern_d = pattern_q;
		enabled_d = enabled_q;
		fleft_d   = fleft_q;
		gesture   = bgl_pkg::GEST_NONE;
		case (phase_q)
			PH_IDLE: begin
				if (pressed) begin
					phase_d   = PH_DEB;
					elapsed_d = '0;
				end
			end
			PH_DEB: begin
				if (!pressed) begin
					gesture = bgl_pkg::GEST_NOISE;
					phase_d = PH_IDLE;
				end else begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= cfg.debounce_ticks) begin
						phase_d   = PH_PRESS1;
						elapsed_d = '0;
					end
				end
			end
			PH_PRESS1: begin
				if (pressed) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= cfg.hold_ticks) begin
						gesture   = bgl_pkg::GEST_HOLD;
						pattern_d = enabled_q ? 2'd0 : 2'd1;
						enabled_d = !enabled_q;
						phase_d   = PH_WAIT;
					end
				end else if (elapsed_q < cfg.click_ticks) begin
					phase_d   = PH_GAP1;
					elapsed_d = '0;
				end else begin
					gesture = bgl_pkg::GEST_NOISE;
					phase_d = PH_IDLE;
				end
			end
			PH_GAP1: begin
				if (!pressed) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= cfg.relax_ticks) begin
						gesture = bgl_pkg::GEST_SINGLE;
						if (enabled_q)
							pattern_d = (pattern_q == 2'd3) ? 2'd1 : pattern_q + 2'd1;
						phase_d = PH_IDLE;
					end
				end else begin
					phase_d   = PH_PRESS2;
					elapsed_d = '0;
				end
			end
			PH_PRESS2: begin
				if (pressed) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= cfg.click_ticks) begin
						gesture = bgl_pkg::GEST_NOISE;
						phase_d = PH_WAIT;
					end
				end else begin
					phase_d   = PH_GAP2;
					elapsed_d = '0;
				end
			end
			PH_GAP2: begin
				if (!pressed) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= cfg.relax_ticks) begin
						gesture = bgl_pkg::GEST_DOUBLE;
						if (cfg.flash_count == '0) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d   = PH_FLASH;
							fleft_d   = cfg.flash_count;
							ftimer_d  = '0;
							elapsed_d = '0;
						end
					end
				end else begin
					gesture = bgl_pkg::GEST_NOISE;
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (!pressed)
					phase_d = PH_IDLE;
			end
			PH_FLASH: begin
				// elapsed marks the half: zero on, one off
				ftimer_d = ftimer_inc;
				if (ftimer_inc >= cfg.flash_half_ticks) begin
					ftimer_d = '0;
					if (elapsed_q == '0) begin
						elapsed_d = {{(bgl_pkg::TICK_W-1){1'b0}}, 1'b1};
					end else begin
						elapsed_d = '0;
						fleft_d   = fleft_dec;
						if (fleft_dec == '0)
							phase_d = pressed ? PH_WAIT : PH_IDLE;
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			ftimer_q  <= '0;
			pattern_q <= '0;
			enabled_q <= 1'b0;
			fleft_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			ftimer_q  <= ftimer_d;
			pattern_q <= pattern_d;
			enabled_q <= enabled_d;
			fleft_q   <= fleft_d;
		end
	end

	assign flash_on = (elapsed_d == '0);

	always_comb begin
		res.gesture = gesture;
		if (phase_d == PH_FLASH) begin
			res.led_one   = flash_on;
			res.led_two   = flash_on;
			res.led_three = flash_on;
		end else begin
			res.led_one   = (pattern_d == 2'd1);
			res.led_two   = (pattern_d == 2'd2);
			res.led_three = (pattern_d == 2'd3);
		end
	end

endmodule

// File: rtl/button_gesture_led_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_led_controller_top
// click, double click and hold detector driving three leds
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction | content
//  ---------+--------------------------------------+-----------+--------------------------
//  s_       | s_tvalid s_tready s_tdata[7:0]       | in        | one ms tick: pressed
//  m_       | m_tvalid m_tready m_tdata[7:0]       | out       | gesture and led levels
//  cfg_     | cfg_valid cfg_ready cfg_index cfg_data | in      | register write
//
//  one item in, one item out; m_tvalid rises once the item has passed s1 and s2
//  sustained rate one item per cycle while s2 is not stalled, set by the state update in bgl_core
//  s1 input register, s2 result register; the state loop closes inside bgl_core
//  s_tready drops only when s1 holds an item and the s2 result is stalled
//  arst_n clears valid bits, state and configuration registers to their reset values
//  cfg writes are always taken (cfg_ready high) and apply from the next item
// ----------------------------------------------------------------------------
module button_gesture_led_controller_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bgl_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] pressed, [7:1] zero
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bgl_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [2:0] gesture, [3] led_one,
	                                                     // [4] led_two, [5] led_three,
	                                                     // [7:6] zero
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bgl_pkg::INDEX_W-1:0]       cfg_index,
	input  logic [bgl_pkg::TICK_W-1:0]        cfg_data
);

	logic             valid_s1;
	logic             pressed_s1;
	logic             valid_s2;
	bgl_pkg::result_t res_s2;
	bgl_pkg::result_t res_next;
	bgl_pkg::cfg_t    cfg;
	logic             advance;
	logic             step;

	// s2 may take a new result when empty or being drained
	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			pressed_s1 <= s_tdata[0];
	end

	bgl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// state machine, updates its state only when the s1 item moves on
	bgl_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.pressed (pressed_s1),
		.cfg     (cfg),
		.res     (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res_next;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2};

endmodule

// File: rtl/bgl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgl_checker
// port-level checks of the button gesture led controller
// ----------------------------------------------------------------------------
`include "button_gesture_led_controller_top_defines.svh"

module bgl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bgl_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// stalled result holds
	`BGL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// input side never blocks while the output register is empty
	`BGL_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "s_tready low with empty output")

	// gesture code in range and padding clear
	`BGL_ASSERT_NOW(a_gesture_range, m_tvalid, (m_tdata[2:0] <= 3'd4) && (m_tdata[7:6] == 2'b00), "bad gesture code or padding")

	// leds show one pattern led or the all-on flash
	`BGL_ASSERT_NOW(a_led_pattern, m_tvalid, $onehot0(m_tdata[5:3]) || (m_tdata[5:3] == 3'b111), "illegal led combination")

endmodule

bind button_gesture_led_controller_top bgl_checker u_bgl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/tb_button_gesture_led_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_gesture_led_controller_top
// self-checking bench for the button gesture led controller: a directed table
// of press and release runs, then random gestures and coin-flip levels under
// several timing settings and flow-control patterns, each result checked against
// its table entry or a local gesture and led predictor
// ----------------------------------------------------------------------------
module tb_button_gesture_led_controller_top;

	localparam int unsigned CYCLE_LIMIT    = 200_000;
	localparam int unsigned TAIL_CYCLES    = 8;      // s1 and s2 pipeline registers plus margin
	localparam int unsigned HOLDOFF_CYCLES = 48;     // long receiver stall, fills the pipe

	// register indexes past the last register, written to show they are ignored
	localparam logic [bgl_pkg::INDEX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [bgl_pkg::INDEX_W-1:0] REG_SPARE_B = 3'd7;

	// predictor states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEBOUNCE,
		ST_FIRST_PRESS,
		ST_FIRST_GAP,
		ST_SECOND_PRESS,
		ST_SECOND_GAP,
		ST_WAIT_RELEASE,
		ST_FLASH
	} gesture_state_t;

	// idling patterns of the two stream sides
	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_SENDER_GAPS,
		FLOW_RECEIVER_STALLS,
		FLOW_BOTH
	} flow_t;

	// one row of the directed table: a run of equal button levels; where typed is
	// set, the item on the last tick of the run must match want exactly
	typedef struct packed {
		logic             level;
		logic [3:0]       ticks;
		logic             typed;
		bgl_pkg::result_t want;
	} press_run_t;

	localparam bgl_pkg::result_t NO_TYPED = '{1'b0, 1'b0, 1'b0, bgl_pkg::GEST_NONE};

	// timing for the table: debounce 1, click 2, relax 1, hold 3, flash half 1, one flash
	// want fields run led_three, led_two, led_one, gesture
	press_run_t directed_runs [31] = '{
		// quiet tick right after reset
		'{1'b0, 4'd1, 1'b1, '{1'b0, 1'b0, 1'b0, bgl_pkg::GEST_NONE}},
		'{1'b1, 4'd2, 1'b0, NO_TYPED},                         // short press
		// single click while disabled
		'{1'b0, 4'd2, 1'b1, '{1'b0, 1'b0, 1'b0, bgl_pkg::GEST_SINGLE}},
		// hold enables, led one lit
		'{1'b1, 4'd5, 1'b1, '{1'b0, 1'b0, 1'b1, bgl_pkg::GEST_HOLD}},
		'{1'b0, 4'd1, 1'b0, NO_TYPED},
		'{1'b1, 4'd2, 1'b0, NO_TYPED},
		'{1'b0, 4'd2, 1'b0, NO_TYPED},                         // click rotates to led two
		'{1'b1, 4'd2, 1'b0, NO_TYPED},
		'{1'b0, 4'd1, 1'b0, NO_TYPED},
		'{1'b1, 4'd1, 1'b0, NO_TYPED},
		// double click, flash starts lit
		'{1'b0, 4'd2, 1'b1, '{1'b1, 1'b1, 1'b1, bgl_pkg::GEST_DOUBLE}},
		'{1'b1, 4'd2, 1'b0, NO_TYPED},                         // press during flash is ignored
		'{1'b0, 4'd1, 1'b0, NO_TYPED},                         // flash ended pressed, release
		'{1'b1, 4'd1, 1'b0, NO_TYPED},
		// release inside debounce
		'{1'b0, 4'd1, 1'b1, '{1'b0, 1'b1, 1'b0, bgl_pkg::GEST_NOISE}},
		'{1'b1, 4'd4, 1'b0, NO_TYPED},
		// first press too long for a click
		'{1'b0, 4'd1, 1'b1, '{1'b0, 1'b1, 1'b0, bgl_pkg::GEST_NOISE}},
		'{1'b1, 4'd2, 1'b0, NO_TYPED},
		'{1'b0, 4'd1, 1'b0, NO_TYPED},
		'{1'b1, 4'd3, 1'b0, NO_TYPED},                         // second press reaches click limit
		'{1'b0, 4'd1, 1'b0, NO_TYPED},
		'{1'b1, 4'd2, 1'b0, NO_TYPED},
		'{1'b0, 4'd1, 1'b0, NO_TYPED},
		'{1'b1, 4'd1, 1'b0, NO_TYPED},
		'{1'b0, 4'd1, 1'b0, NO_TYPED},
		'{1'b1, 4'd1, 1'b0, NO_TYPED},                         // press inside the second gap
		'{1'b0, 4'd1, 1'b0, NO_TYPED},
		'{1'b1, 4'd2, 1'b0, NO_TYPED},
		'{1'b0, 4'd2, 1'b0, NO_TYPED},                         // click rotates to led three
		'{1'b1, 4'd2, 1'b0, NO_TYPED},
		// rotation wraps to led one
		'{1'b0, 4'd2, 1'b1, '{1'b0, 1'b0, 1'b1, bgl_pkg::GEST_SINGLE}}
	};

	// dut connections, every input known from time zero
	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [bgl_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [bgl_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [bgl_pkg::INDEX_W-1:0]     cfg_index = '0;
	logic [bgl_pkg::TICK_W-1:0]      cfg_data  = '0;

	// predictor state and register mirror
	bgl_pkg::cfg_t  timing;
	gesture_state_t gest_state;
	logic [15:0]    dwell_ticks;    // ticks in the current state, 0/1 = lit/dark half in flash
	logic [1:0]     pattern;
	logic           enabled;
	logic [3:0]     flashes_left;
	logic [15:0]    flash_timer;

	// expected results in acceptance order
	bgl_pkg::result_t expected_results [$];

	// flow control and bookkeeping
	int unsigned sender_gap_pct     = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned stall_request      = 0;
	int unsigned stall_served       = 0;
	int unsigned holdoff_left       = 0;
	int unsigned cycle_count        = 0;
	int unsigned mismatch_count     = 0;
	int unsigned ticks_sent         = 0;
	int unsigned results_seen       = 0;
	int unsigned reg_writes         = 0;
	int unsigned settings_used      = 0;

	button_gesture_led_controller_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [0] pressed, [7:1] zero
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // [2:0] gesture, [3] led_one, [4] led_two, [5] led_three,
		                         // [7:6] zero
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still outstanding",
				cycle_count, expected_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// long receiver hold-off, counted here so the sender keeps offering meanwhile
	always @(posedge clk) begin
		if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (stall_request != stall_served) begin
			holdoff_left <= HOLDOFF_CYCLES;
			stall_served <= stall_request;
		end
	end

	// receiver side: random stalls by the current pattern, ready held low during a hold-off
	always @(negedge clk) begin
		m_tready <= (holdoff_left == 0) && ($urandom_range(99, 0) >= receiver_stall_pct);
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		$display("[%0t] %s: got %0d, expected %0d (result %0d)",
			$time, what, got, want, results_seen);
	endtask

	// result checker, compares field by field against the oldest expectation
	always @(posedge clk) begin
		bgl_pkg::result_t got;
		bgl_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = bgl_pkg::result_t'(m_tdata[5:0]);
			if (expected_results.size() == 0) begin
				report_mismatch("result item with nothing outstanding", 32'(m_tdata), 0);
			end else begin
				want = expected_results.pop_front();
				if (got.gesture !== want.gesture)
					report_mismatch("gesture", 32'(got.gesture), 32'(want.gesture));
				if (got.led_one !== want.led_one)
					report_mismatch("led_one", 32'(got.led_one), 32'(want.led_one));
				if (got.led_two !== want.led_two)
					report_mismatch("led_two", 32'(got.led_two), 32'(want.led_two));
				if (got.led_three !== want.led_three)
					report_mismatch("led_three", 32'(got.led_three), 32'(want.led_three));
				if (m_tdata[7:6] !== 2'b00)
					report_mismatch("tdata padding", 32'(m_tdata[7:6]), 0);
			end
			results_seen++;
		end
	end

	function automatic void bump_dwell();
		if (dwell_ticks != 16'hFFFF)
			dwell_ticks++;
	endfunction

	// one millisecond tick of the gesture detector and led logic
	function automatic bgl_pkg::result_t predict_tick(input logic pressed);
		bgl_pkg::result_t res;
		logic             lit;
		res = NO_TYPED;
		case (gest_state)
			ST_IDLE: begin
				if (pressed) begin
					gest_state  = ST_DEBOUNCE;
					dwell_ticks = '0;
				end
			end
			ST_DEBOUNCE: begin
				if (!pressed) begin
					res.gesture = bgl_pkg::GEST_NOISE;
					gest_state  = ST_IDLE;
				end else begin
					bump_dwell();
					if (dwell_ticks >= timing.debounce_ticks) begin
						gest_state  = ST_FIRST_PRESS;
						dwell_ticks = '0;
					end
				end
			end
			ST_FIRST_PRESS: begin
				if (pressed) begin
					bump_dwell();
					// hold acts at once and toggles between all dark and led one
					if (dwell_ticks >= timing.hold_ticks) begin
						res.gesture = bgl_pkg::GEST_HOLD;
						enabled     = !enabled;
						pattern     = enabled ? 2'd1 : 2'd0;
						gest_state  = ST_WAIT_RELEASE;
					end
				end else if (dwell_ticks < timing.click_ticks) begin
					gest_state  = ST_FIRST_GAP;
					dwell_ticks = '0;
				end else begin
					res.gesture = bgl_pkg::GEST_NOISE;
					gest_state  = ST_IDLE;
				end
			end
			ST_FIRST_GAP: begin
				if (!pressed) begin
					bump_dwell();
					if (dwell_ticks >= timing.relax_ticks) begin
						res.gesture = bgl_pkg::GEST_SINGLE;
						if (enabled)
							pattern = (pattern == 2'd3) ? 2'd1 : pattern + 2'd1;
						gest_state = ST_IDLE;
					end
				end else begin
					gest_state  = ST_SECOND_PRESS;
					dwell_ticks = '0;
				end
			end
			ST_SECOND_PRESS: begin
				if (pressed) begin
					bump_dwell();
					if (dwell_ticks >= timing.click_ticks) begin
						res.gesture = bgl_pkg::GEST_NOISE;
						gest_state  = ST_WAIT_RELEASE;
					end
				end else begin
					gest_state  = ST_SECOND_GAP;
					dwell_ticks = '0;
				end
			end
			ST_SECOND_GAP: begin
				if (!pressed) begin
					bump_dwell();
					if (dwell_ticks >= timing.relax_ticks) begin
						res.gesture = bgl_pkg::GEST_DOUBLE;
						if (timing.flash_count == '0) begin
							gest_state = ST_IDLE;
						end else begin
							gest_state   = ST_FLASH;
							flashes_left = timing.flash_count;
							flash_timer  = '0;
							dwell_ticks  = '0;
						end
					end
				end else begin
					res.gesture = bgl_pkg::GEST_NOISE;
					gest_state  = ST_WAIT_RELEASE;
				end
			end
			ST_WAIT_RELEASE: begin
				if (!pressed)
					gest_state = ST_IDLE;
			end
			default: begin
				// flash: presses ignored, lit half then dark half per flash
				if (flash_timer != 16'hFFFF)
					flash_timer++;
				if (flash_timer >= timing.flash_half_ticks) begin
					flash_timer = '0;
					if (dwell_ticks == '0) begin
						dwell_ticks = 16'd1;
					end else begin
						dwell_ticks = '0;
						if (flashes_left != '0)
							flashes_left--;
						if (flashes_left == '0)
							gest_state = pressed ? ST_WAIT_RELEASE : ST_IDLE;
					end
				end
			end
		endcase

		if (gest_state == ST_FLASH) begin
			lit           = (dwell_ticks == '0);
			res.led_one   = lit;
			res.led_two   = lit;
			res.led_three = lit;
		end else begin
			res.led_one   = (pattern == 2'd1);
			res.led_two   = (pattern == 2'd2);
			res.led_three = (pattern == 2'd3);
		end
		return res;
	endfunction

	// offer one tick item, wait for acceptance, then queue its expected result;
	// s_tvalid stays high afterwards so back-to-back items need no extra edge
	task automatic send_tick(input logic level, input logic typed,
			input bgl_pkg::result_t want);
		bgl_pkg::result_t predicted;
		@(negedge clk);
		while ($urandom_range(99, 0) < sender_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(bgl_pkg::IN_TDATA_W-1){1'b0}}, level};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = predict_tick(level);
		expected_results.push_back(typed ? want : predicted);
		ticks_sent++;
	endtask

	task automatic send_run(input logic level, input int n);
		repeat (n) send_tick(level, 1'b0, NO_TYPED);
	endtask

	// sender goes quiet until every queued result has come back
	task automatic wait_results_settled();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [bgl_pkg::INDEX_W-1:0] idx,
			input logic [bgl_pkg::TICK_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			bgl_pkg::REG_DEBOUNCE:   timing.debounce_ticks   = data;
			bgl_pkg::REG_CLICK:      timing.click_ticks      = data;
			bgl_pkg::REG_RELAX:      timing.relax_ticks      = data;
			bgl_pkg::REG_HOLD:       timing.hold_ticks       = data;
			bgl_pkg::REG_FLASH_HALF: timing.flash_half_ticks = data;
			bgl_pkg::REG_FLASH_CNT:  timing.flash_count      = data[bgl_pkg::COUNT_W-1:0];
			default: ;      // spare indexes have no register
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// only called with both streams idle and the pipeline drained
	task automatic apply_timing(input logic [15:0] debounce, input logic [15:0] click,
			input logic [15:0] relax, input logic [15:0] hold,
			input logic [15:0] flash_half, input logic [15:0] flashes);
		write_register(bgl_pkg::REG_DEBOUNCE, debounce);
		write_register(bgl_pkg::REG_CLICK, click);
		write_register(bgl_pkg::REG_RELAX, relax);
		write_register(bgl_pkg::REG_HOLD, hold);
		write_register(bgl_pkg::REG_FLASH_HALF, flash_half);
		write_register(bgl_pkg::REG_FLASH_CNT, flashes);
		settings_used++;
	endtask

	// random register value between lo and hi
	function automatic logic [15:0] rand_ticks(input int unsigned hi, input int unsigned lo);
		return 16'($urandom_range(hi, lo));
	endfunction

	function automatic int upto(input int n);
		return (n <= 0) ? 0 : int'($urandom_range(n, 0));
	endfunction

	// one gesture attempt, with run lengths chosen around the current limits
	task automatic play_gesture();
		int pick;
		int deb;
		int clk_lim;
		int rlx;
		int hld;
		int flash_len;
		deb     = int'(timing.debounce_ticks);
		clk_lim = int'(timing.click_ticks);
		rlx     = int'(timing.relax_ticks);
		hld     = int'(timing.hold_ticks);
		pick    = int'($urandom_range(99, 0));
		if (pick < 30) begin
			// single click
			send_run(1'b1, 1 + deb + upto(clk_lim - 1));
			send_run(1'b0, rlx + 1 + upto(2));
		end else if (pick < 55) begin
			// double click, then random presses while the leds flash
			send_run(1'b1, 1 + deb + upto(clk_lim - 1));
			send_run(1'b0, 1 + upto(rlx - 1));
			send_run(1'b1, 1 + upto(clk_lim - 1));
			send_run(1'b0, rlx + 1);
			flash_len = 2 * ((timing.flash_half_ticks == 0) ? 1 : int'(timing.flash_half_ticks))
				* int'(timing.flash_count) + 1;
			repeat (flash_len) send_tick($urandom_range(3, 0) == 0, 1'b0, NO_TYPED);
			send_run(1'b0, 1 + upto(1));
		end else if (pick < 70) begin
			// hold, then release
			send_run(1'b1, 1 + deb + hld + upto(2));
			send_run(1'b0, 1 + upto(1));
		end else begin
			// bounces and badly timed presses
			repeat (1 + upto(2)) begin
				send_run(1'b1, 1 + upto(deb + clk_lim + hld + 2));
				send_run(1'b0, 1 + upto(rlx + 2));
			end
		end
	endtask

	task automatic set_flow(input flow_t flow);
		case (flow)
			FLOW_FREE:            begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
			FLOW_SENDER_GAPS:     begin sender_gap_pct = 64; receiver_stall_pct = 0;  end
			FLOW_RECEIVER_STALLS: begin sender_gap_pct = 0;  receiver_stall_pct = 64; end
			default:              begin sender_gap_pct = 32; receiver_stall_pct = 32; end
		endcase
	endtask

	// one random stretch under the current timing; shaped plays gestures,
	// otherwise levels are plain coin flips
	task automatic run_stretch(input flow_t flow, input int unsigned budget, input bit shaped,
			input bit holdoff, input bit midway_pause);
		int unsigned start;
		bit          holdoff_done;
		bit          pause_done;
		start        = ticks_sent;
		holdoff_done = 1'b0;
		pause_done   = 1'b0;
		set_flow(flow);
		while (ticks_sent - start < budget) begin
			if (holdoff && !holdoff_done && ticks_sent - start >= budget / 4) begin
				stall_request++;
				holdoff_done = 1'b1;
			end
			if (midway_pause && !pause_done && ticks_sent - start >= budget / 2) begin
				wait_results_settled();
				pause_done = 1'b1;
			end
			if (shaped)
				play_gesture();
			else
				send_tick(1'($urandom_range(1, 0)), 1'b0, NO_TYPED);
		end
		// settle, then let the pipeline empty before any register write
		wait_results_settled();
		repeat (TAIL_CYCLES) @(posedge clk);
		set_flow(FLOW_FREE);
	endtask

	initial begin
		// predictor reset state, registers at their reset values
		timing       = '{bgl_pkg::DEBOUNCE_RST, bgl_pkg::CLICK_RST, bgl_pkg::RELAX_RST,
			bgl_pkg::HOLD_RST, bgl_pkg::FLASH_HALF_RST, bgl_pkg::FLASH_CNT_RST};
		gest_state   = ST_IDLE;
		dwell_ticks  = '0;
		pattern      = '0;
		enabled      = 1'b0;
		flashes_left = '0;
		flash_timer  = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table under tight timing
		set_flow(FLOW_FREE);
		apply_timing(16'd1, 16'd2, 16'd1, 16'd3, 16'd1, 16'd1);
		foreach (directed_runs[i]) begin
			for (int k = 0; k < directed_runs[i].ticks; k++)
				send_tick(directed_runs[i].level,
					directed_runs[i].typed && (k == directed_runs[i].ticks - 1),
					directed_runs[i].want);
		end
		wait_results_settled();
		repeat (TAIL_CYCLES) @(posedge clk);

		// small random timing, no idling
		apply_timing(rand_ticks(3, 1), rand_ticks(6, 2), rand_ticks(4, 1),
			rand_ticks(10, 3), rand_ticks(3, 1), rand_ticks(3, 0));
		run_stretch(FLOW_FREE, 100, 1'b1, 1'b0, 1'b0);

		// every limit zero: reached at once
		apply_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_stretch(FLOW_SENDER_GAPS, 60, 1'b1, 1'b0, 1'b0);

		// click limit zero makes every release noise; spare indexes must be ignored
		apply_timing(rand_ticks(3, 1), 16'd0, rand_ticks(4, 1),
			rand_ticks(10, 3), rand_ticks(3, 1), rand_ticks(3, 1));
		write_register(REG_SPARE_A, 16'hFFFF);
		write_register(REG_SPARE_B, 16'h0000);
		run_stretch(FLOW_RECEIVER_STALLS, 80, 1'b1, 1'b0, 1'b0);

		// no flashes: a double click shows the pattern at once
		apply_timing(rand_ticks(3, 1), rand_ticks(6, 2), rand_ticks(4, 1),
			rand_ticks(10, 3), rand_ticks(3, 1), 16'd0);
		run_stretch(FLOW_BOTH, 100, 1'b1, 1'b0, 1'b0);

		// every limit at its maximum, count field gets its low four bits
		apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_stretch(FLOW_BOTH, 40, 1'b0, 1'b0, 1'b0);

		// fifteen flashes with single-tick halves, with a long receiver hold-off
		apply_timing(rand_ticks(3, 1), rand_ticks(6, 2), rand_ticks(4, 1),
			rand_ticks(10, 3), 16'd0, 16'd15);
		run_stretch(FLOW_FREE, 130, 1'b1, 1'b1, 1'b0);

		// sender gaps, with a pause until everything has come back
		apply_timing(rand_ticks(3, 1), rand_ticks(6, 2), rand_ticks(4, 1),
			rand_ticks(10, 3), rand_ticks(3, 1), rand_ticks(3, 0));
		run_stretch(FLOW_SENDER_GAPS, 120, 1'b1, 1'b0, 1'b1);

		apply_timing(rand_ticks(3, 1), rand_ticks(6, 2), rand_ticks(4, 1),
			rand_ticks(10, 3), rand_ticks(3, 1), rand_ticks(3, 0));
		run_stretch(FLOW_RECEIVER_STALLS, 110, 1'b1, 1'b0, 1'b0);

		apply_timing(rand_ticks(3, 1), rand_ticks(6, 2), rand_ticks(4, 1),
			rand_ticks(10, 3), rand_ticks(3, 1), rand_ticks(3, 0));
		run_stretch(FLOW_BOTH, 90, 1'b1, 1'b0, 1'b0);

		if (expected_results.size() != 0)
			report_mismatch("results never returned", expected_results.size(), 0);

		$display("ran %0d tick items through %0d timing settings (%0d register writes),",
			ticks_sent, settings_used, reg_writes);
		$display("checked %0d result items with idle, stall and hold-off patterns, %0d errors",
			results_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
